[hw/rtl/block_rms_level_macros.svh]
// ----------------------------------------------------------------------------
// block_rms_level_macros.svh
// Assertion helper macros for the block RMS level meter.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_LEVEL_MACROS_SVH
`define BLOCK_RMS_LEVEL_MACROS_SVH

`ifndef SYNTH
// cons must hold in the same cycle as ante
`define BRMS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("brms assertion failed");
// cons must hold in the cycle after ante
`define BRMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("brms assertion failed");
`else
`define BRMS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BRMS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/brms_pkg.sv]
// ----------------------------------------------------------------------------
// brms_pkg
// Shared widths and types for the block RMS level meter.
// ----------------------------------------------------------------------------
package brms_pkg;

    localparam int MAX_BLOCK   = 4096;
    localparam int SAMPLE_BITS = 16;

    // square of a magnitude up to 2^(SAMPLE_BITS-1)
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int COUNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = SQ_W + $clog2(MAX_BLOCK);
    localparam int ROOT_W  = SAMPLE_BITS;

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ROOT_W + COUNT_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one closed block, handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               truncated;
    } blk_t;

endpackage

[hw/rtl/brms_front.sv]
// ----------------------------------------------------------------------------
// brms_front
// Sample intake: squares each sample, counts and accumulates the block,
// and hands a closed block to the queue.
// ----------------------------------------------------------------------------
module brms_front
    import brms_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   block_end,
    input  logic                   q_ready,
    output logic                   q_push,
    output blk_t                   q_blk
);

    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   st_valid_reg, st_valid_next;
    logic [SQ_W-1:0]        st_sq_reg;
    logic                   st_close_reg;
    logic                   st_trunc_reg;
    logic [COUNT_W-1:0]     st_cnt_reg;

    logic                   accept;
    logic                   st_fire;
    logic [COUNT_W-1:0]     cnt_inc;
    logic                   close;
    logic [SAMPLE_BITS-1:0] mag;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [SUM_W-1:0]       sum_add;

    assign st_fire  = st_valid_reg && (!st_close_reg || q_ready);
    assign s_tready = !st_valid_reg || st_fire;
    assign accept   = s_tvalid && s_tready;

    assign cnt_inc = cnt_reg + COUNT_W'(1);
    assign close   = block_end || (cnt_inc == COUNT_W'(MAX_BLOCK));

    // two's complement negate wraps the most negative code onto 2^(N-1)
    assign mag     = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign sq_full = mag * mag;
    assign sum_add = sum_reg + SUM_W'(st_sq_reg);

    assign q_push          = st_fire && st_close_reg;
    assign q_blk.sum       = sum_add;
    assign q_blk.count     = st_cnt_reg;
    assign q_blk.truncated = st_trunc_reg;

    always_comb begin
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        st_valid_next = st_valid_reg;
        if (accept) begin
            cnt_next = close ? '0 : cnt_inc;
        end
        if (st_fire) begin
            sum_next = st_close_reg ? '0 : sum_add;
        end
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_fire) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            sum_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_sq_reg    <= sq_full[SQ_W-1:0];
            st_close_reg <= close;
            st_trunc_reg <= !block_end;
            st_cnt_reg   <= cnt_inc;
        end
    end

endmodule

[hw/rtl/brms_queue.sv]
// ----------------------------------------------------------------------------
// brms_queue
// Short register FIFO of closed blocks between intake and the root unit.
// ----------------------------------------------------------------------------
`include "block_rms_level_macros.svh"

module brms_queue
    import brms_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  blk_t push_blk,
    output logic ready,
    input  logic pop,
    output logic empty,
    output blk_t head
);

    blk_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              full;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign ready = !full;
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_blk;
        end
    end

    `BRMS_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !full)
    `BRMS_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, !empty)

endmodule

[hw/rtl/brms_back.sv]
// ----------------------------------------------------------------------------
// brms_back
// Root unit: restoring divide of the block sum by its count, then a
// digit-by-digit square root, into a registered result stage.
// ----------------------------------------------------------------------------
`include "block_rms_level_macros.svh"

module brms_back
    import brms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  blk_t               q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ROOT_W-1:0]  level,
    output logic [COUNT_W-1:0] sample_count,
    output logic               truncated
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [SQ_W-1:0] PROBE_START = SQ_W'(1) << (2 * (ROOT_W - 1));
    localparam logic [SQ_W-1:0] ROOT_MAX    = SQ_W'(1) << (ROOT_W - 1);

    logic [1:0]         state_reg, state_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SQ_W-1:0]    x_reg, x_next;
    logic [SQ_W-1:0]    res_reg, res_next;
    logic [SQ_W-1:0]    probe_reg, probe_next;
    logic [COUNT_W-1:0] blk_cnt_reg, blk_cnt_next;
    logic               blk_trunc_reg, blk_trunc_next;

    logic               m_valid_reg, m_valid_next;
    logic [ROOT_W-1:0]  level_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               trunc_reg;

    logic [COUNT_W:0]   trial;
    logic               trial_ge;
    logic [SUM_W-1:0]   quo_step;
    logic [SQ_W:0]      cand;
    logic               cand_ge;
    logic               load_out;

    // one quotient bit per cycle; remainder always below the divisor
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign quo_step = {quo_reg[SUM_W-2:0], trial_ge};

    // one root bit per cycle
    assign cand    = {1'b0, res_reg} + {1'b0, probe_reg};
    assign cand_ge = ({1'b0, x_reg} >= cand);

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_LOAD) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        probe_next     = probe_reg;
        blk_cnt_next   = blk_cnt_reg;
        blk_trunc_next = blk_trunc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    quo_next       = q_head.sum;
                    div_next       = q_head.count;
                    rem_next       = '0;
                    step_next      = '0;
                    blk_cnt_next   = q_head.count;
                    blk_trunc_next = q_head.truncated;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next  = quo_step;
                rem_next  = trial_ge ? COUNT_W'(trial - {1'b0, div_reg})
                                     : trial[COUNT_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    // mean never exceeds the largest square
                    x_next     = quo_step[SQ_W-1:0];
                    res_next   = '0;
                    probe_next = PROBE_START;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (cand_ge) begin
                    x_next   = x_reg - cand[SQ_W-1:0];
                    res_next = (res_reg >> 1) + probe_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                probe_next = probe_reg >> 2;
                if (probe_reg[0]) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        step_reg      <= step_next;
        x_reg         <= x_next;
        res_reg       <= res_next;
        probe_reg     <= probe_next;
        blk_cnt_reg   <= blk_cnt_next;
        blk_trunc_reg <= blk_trunc_next;
        if (load_out) begin
            level_reg <= res_reg[ROOT_W-1:0];
            count_reg <= blk_cnt_reg;
            trunc_reg <= blk_trunc_reg;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign level        = level_reg;
    assign sample_count = count_reg;
    assign truncated    = trunc_reg;

    `BRMS_ASSERT_SAME(a_rem_below_div, aclk, aresetn, state_reg == ST_DIV, rem_reg < div_reg)
    `BRMS_ASSERT_NEXT(a_pop_starts_div, aclk, aresetn, q_pop, state_reg == ST_DIV)
    `BRMS_ASSERT_SAME(a_root_in_range, aclk, aresetn, load_out, res_reg <= ROOT_MAX)

endmodule

[hw/rtl/block_rms_level.sv]
// ----------------------------------------------------------------------------
// block_rms_level
// Block RMS level meter: streams signed Q1.15 samples, reports the floored
// RMS of each block as unsigned Q1.15 with its length and a truncation flag.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle; a sample with tlast closes its block, and
// a block that reaches 4096 samples without tlast closes by itself and is
// reported with tuser set. Intake squares each sample and sums the block; a
// closed block waits in a two-entry queue for the root unit, which pops it
// in its idle state, then runs the restoring divide (one quotient bit a
// cycle over the 43-bit sum) and the square root (one root bit a cycle) and
// loads the result register, waiting there while the output is stalled.
// Intake keeps taking samples while the root unit works; it stalls only
// when a block closes while the queue already holds two blocks. So blocks
// that take as long to arrive as the root unit spends on a block stream at
// one sample per cycle while the output is not stalled, and shorter blocks
// are paced by the root unit.
// ----------------------------------------------------------------------------
module block_rms_level
    import brms_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample (signed Q1.15)
    input  logic                   s_tlast,   // block_end
    // level output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] level, [28:16] sample_count
    output logic                   m_tuser    // truncated
);

    logic               q_ready;
    logic               q_push;
    blk_t               q_push_blk;
    logic               q_pop;
    logic               q_empty;
    blk_t               q_head;
    logic [ROOT_W-1:0]  level;
    logic [COUNT_W-1:0] sample_count;

    // intake: square and accumulate
    brms_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .block_end (s_tlast),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_blk     (q_push_blk)
    );

    // closed blocks waiting for the root unit
    brms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_blk (q_push_blk),
        .ready    (q_ready),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // mean and root, result register
    brms_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .level        (level),
        .sample_count (sample_count),
        .truncated    (m_tuser)
    );

    // pack fields from the low end, zero fill to the byte
    assign m_tdata = OUT_TDATA_W'({sample_count, level});

endmodule
